[rtl/lees_pkg.sv]
// Shared types and constants for the linear extreme extract store.
// Used by lees_cell and by the top level linear_extreme_extract_store.
package lees_pkg;

    localparam int CAPACITY = 128;
    localparam int VAL_W    = 31;
    localparam int IN_W     = 32;
    localparam int OCC_W    = 8;
    localparam int STAT_W   = 2;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_RAW  = VAL_W + STAT_W + OCC_W;
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_MIN = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NEGATIVE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // Control broadcast to every cell
    typedef struct packed {
        logic              load;
        logic              shift;
        logic              mode;
        logic [VAL_W-1:0]  data;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  pos;
    } t_cell_ctl;

    // Search token moving down the chain
    typedef struct packed {
        logic              tok;
        logic              has;
        logic [VAL_W-1:0]  val;
        logic [IDX_W-1:0]  pos;
    } t_scan;

endpackage

[rtl/lees_cell.sv]
// One storage cell of the chain: holds one entry, loads on append, takes its
// right neighbor on gap closing, and updates the passing search token.
// Depends on lees_pkg.
module lees_cell
    import lees_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctl        i_ctl,
    input  logic [VAL_W-1:0] i_right,
    input  t_scan            i_scan,
    output t_scan            o_scan,
    output logic [VAL_W-1:0] o_value
);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    t_scan            r_scan;
    t_scan            n_scan;
    logic             w_valid;
    logic             w_better;

    assign w_valid  = CNT_W'(i_index) < i_ctl.count;
    assign w_better = (i_ctl.mode == MODE_MIN) ? (r_value < i_scan.val)
                                               : (r_value > i_scan.val);

    always_comb begin
        n_value = r_value;
        if (i_ctl.load && (CNT_W'(i_index) == i_ctl.count)) begin
            n_value = i_ctl.data;
        end else if (i_ctl.shift && (i_index >= i_ctl.pos)) begin
            n_value = i_right;
        end
    end

    always_comb begin
        n_scan = i_scan;
        if (i_scan.tok && w_valid && (!i_scan.has || w_better)) begin
            n_scan.has = 1'b1;
            n_scan.val = r_value;
            n_scan.pos = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_scan.has <= n_scan.has;
        r_scan.val <= n_scan.val;
        r_scan.pos <= n_scan.pos;
        if (!i_rst_n) begin
            r_scan.tok <= 1'b0;
        end else begin
            r_scan.tok <= n_scan.tok;
        end
    end

    assign o_scan  = r_scan;
    assign o_value = r_value;

endmodule

[rtl/linear_extreme_extract_store.sv]
// Top level of the linear extreme extract store: control sequencer, mode
// register, output register and the chain of lees_cell storage cells.
// Depends on lees_pkg and lees_cell.
//
// Usage:
//   Input beats on the s_axis channel: tuser[0] is the command (0 insert,
//   1 remove), tdata is the 32-bit signed value to insert.
//   Every input beat yields one output beat on m_axis carrying the removed
//   value, a status code and the occupancy after the beat.
//   The extract mode register (0 largest, 1 smallest) is written through the
//   cfg channel, which is always ready; write it only while the block idles.
//   Insert, rejected insert and empty remove: the execute state writes the
//   result to the output register and returns to idle. Remove on a non-empty
//   store: a token walks the chain one cell per cycle, then the result is
//   written and the cells past the chosen entry shift left at once.
//   One item is processed at a time; s_axis_tready is high only while idle.
//   A finished result waits in the output register while the next item is
//   accepted; a stalled receiver holds the block at the end of that item.
//   Reset empties the store and sets the mode to largest; no clearing pass.
module linear_extreme_extract_store
    import lees_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_data,       // extract_mode
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // value
    input  logic [0:0]       i_s_axis_tuser,   // command
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // removed_value, status, occupancy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic              r_mode;
    logic              r_cmd;
    logic [IN_W-1:0]   r_val;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [VAL_W-1:0]  r_best_val;
    logic [IDX_W-1:0]  r_best_pos;
    logic              r_m_valid, n_m_valid;
    logic [OUT_W-1:0]  r_m_data, n_m_data;

    logic              w_out_free;
    logic              w_empty;
    logic              w_full;
    logic              w_load;
    logic              w_shift;
    logic              w_inject;
    logic              w_emit;
    logic [STAT_W-1:0] w_status;
    logic [VAL_W-1:0]  w_removed;
    t_cell_ctl         w_ctl;
    t_scan             w_scan_in;
    t_scan             w_scan [CAPACITY];
    logic [VAL_W-1:0]  w_value [CAPACITY];

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_out_free      = !r_m_valid || i_m_axis_tready;
    assign w_empty         = (r_count == '0);
    assign w_full          = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        w_load    = 1'b0;
        w_shift   = 1'b0;
        w_inject  = 1'b0;
        w_emit    = 1'b0;
        w_status  = ST_OK;
        w_removed = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_INSERT) begin
                    if (r_val[IN_W-1]) begin
                        w_status = ST_NEGATIVE;
                    end else if (w_full) begin
                        w_status = ST_FULL;
                    end
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                        if (w_status == ST_OK) begin
                            w_load  = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                end else if (w_empty) begin
                    w_status = ST_EMPTY;
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    w_inject = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan[CAPACITY-1].tok) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_removed = r_best_val;
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_shift = 1'b1;
                    n_count = r_count - 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_data  = r_m_data;
        if (w_emit) begin
            n_m_valid = 1'b1;
            n_m_data  = OUT_W'({OCC_W'(n_count), w_status, w_removed});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_MAX;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        if ((r_state == S_IDLE) && i_s_axis_tvalid) begin
            r_cmd <= i_s_axis_tuser[0];
            r_val <= i_s_axis_tdata;
        end
        if ((r_state == S_SCAN) && w_scan[CAPACITY-1].tok) begin
            r_best_val <= w_scan[CAPACITY-1].val;
            r_best_pos <= w_scan[CAPACITY-1].pos;
        end
    end

    assign w_ctl.load  = w_load;
    assign w_ctl.shift = w_shift;
    assign w_ctl.mode  = r_mode;
    assign w_ctl.data  = r_val[VAL_W-1:0];
    assign w_ctl.count = r_count;
    assign w_ctl.pos   = r_best_pos;

    assign w_scan_in.tok = w_inject;
    assign w_scan_in.has = 1'b0;
    assign w_scan_in.val = '0;
    assign w_scan_in.pos = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_scan            w_prev;
            logic [VAL_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_prev = w_scan_in;
            end else begin : g_mid
                assign w_prev = w_scan[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_value[g];
            end else begin : g_inner
                assign w_right = w_value[g+1];
            end
            lees_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IDX_W'(g)),
                .i_ctl   (w_ctl),
                .i_right (w_right),
                .i_scan  (w_prev),
                .o_scan  (w_scan[g]),
                .o_value (w_value[g])
            );
        end
    endgenerate

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("entry count changed during search");

    a_token_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan[CAPACITY-1].tok |-> (r_state == S_SCAN))
        else $error("search token outside search phase");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_m_data[VAL_W+STAT_W-1:VAL_W] == ST_EMPTY))
            |-> ((r_m_data[VAL_W-1:0] == '0)
                 && (r_m_data[VAL_W+STAT_W+OCC_W-1:VAL_W+STAT_W] == '0)))
        else $error("empty remove result carries data");
`endif

endmodule

[dv/linear_extreme_extract_store_tb.sv]
// Self-checking testbench for linear_extreme_extract_store: directed and random
// insert/remove beats, both extract modes, random stalls on both streams.
// Depends on lees_pkg and the RTL of the store.
module linear_extreme_extract_store_tb;
    import lees_pkg::*;

    typedef struct {
        logic [VAL_W-1:0]  removed;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occ;
    } t_outcome;

    class lees_scoreboard;
        logic [VAL_W-1:0] stored[$];
        t_outcome         outcomes[$];
        logic             mode;
        int               errors;

        function new();
            mode   = MODE_MAX;
            errors = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        // Predict the result of one accepted command beat
        function void note_command(logic cmd, logic [IN_W-1:0] val);
            t_outcome o;
            int       pick;
            o.removed = '0;
            o.status  = ST_OK;
            if (cmd == CMD_INSERT) begin
                if (val[IN_W-1])
                    o.status = ST_NEGATIVE;
                else if (stored.size() >= CAPACITY)
                    o.status = ST_FULL;
                else
                    stored.push_back(val[VAL_W-1:0]);
            end else if (stored.size() == 0) begin
                o.status = ST_EMPTY;
            end else begin
                pick = 0;
                for (int i = 1; i < stored.size(); i++) begin
                    if (mode == MODE_MIN ? stored[i] < stored[pick]
                                         : stored[i] > stored[pick])
                        pick = i;
                end
                o.removed = stored[pick];
                stored.delete(pick);
            end
            o.occ = OCC_W'(stored.size());
            outcomes.push_back(o);
        endfunction

        function void check_outcome(logic [OUT_W-1:0] beat);
            t_outcome want;
            logic [VAL_W-1:0]  got_removed;
            logic [STAT_W-1:0] got_status;
            logic [OCC_W-1:0]  got_occ;
            got_removed = beat[VAL_W-1:0];
            got_status  = beat[VAL_W +: STAT_W];
            got_occ     = beat[VAL_W+STAT_W +: OCC_W];
            if (outcomes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result beat %h", beat);
                return;
            end
            want = outcomes.pop_front();
            if (got_removed !== want.removed || got_status !== want.status
                    || got_occ !== want.occ) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: exp value %h status %0d occ %0d, got %h %0d %0d",
                             want.removed, want.status, want.occ,
                             got_removed, got_status, got_occ);
            end
        endfunction
    endclass

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [0:0]       cfg_data = '0;
    logic             s_valid  = 1'b0;
    logic [IN_W-1:0]  s_data   = '0;
    logic [0:0]       s_user   = '0;
    logic             m_ready  = 1'b0;
    logic             cfg_ready;
    logic             s_ready;
    logic             m_valid;
    logic [OUT_W-1:0] m_data;

    lees_scoreboard sb;
    bit             idle_on;
    int             stall_left;

    linear_extreme_extract_store uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #6 clk = ~clk;

    // Result side: check accepted beats and, while idle_on is set, drop m_ready at random
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_valid && m_ready)
                sb.check_outcome(m_data);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_command(logic cmd, logic [IN_W-1:0] val);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= val;
        s_user  <= cmd;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        sb.note_command(cmd, val);
    endtask

    // Mode changes only with the store idle and every result delivered
    task automatic set_extract_mode(logic m);
        s_valid <= 1'b0;
        @(posedge clk);
        while (sb.outcomes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_mode(m);
    endtask

    function automatic logic [IN_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return {1'b1, 31'($urandom)};
            2:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3, 4:    return $urandom_range(0, 15);
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    initial begin
        int ins_pct[8];
        logic cmd;
        ins_pct = '{95, 50, 30, 90, 50, 15, 60, 50};
        sb = new();
        idle_on = 1'b1;
        stall_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_extract_mode(MODE_MAX);
        push_command(CMD_REMOVE, 32'h0);
        push_command(CMD_INSERT, 32'h0000_0000);
        push_command(CMD_INSERT, 32'h7FFF_FFFF);
        push_command(CMD_INSERT, 32'h8000_0000);
        push_command(CMD_INSERT, 32'hFFFF_FFFF);
        push_command(CMD_INSERT, 32'd5);
        push_command(CMD_INSERT, 32'd5);
        push_command(CMD_INSERT, 32'h7FFF_FFFF);
        repeat (6) push_command(CMD_REMOVE, 32'hFFFF_FFFF);
        set_extract_mode(MODE_MIN);
        push_command(CMD_INSERT, 32'd3);
        push_command(CMD_INSERT, 32'd1);
        push_command(CMD_INSERT, 32'd1);
        push_command(CMD_INSERT, 32'h7FFF_FFFF);
        push_command(CMD_INSERT, 32'd9);
        repeat (6) push_command(CMD_REMOVE, 32'h8000_0000);

        for (int ph = 0; ph < 8; ph++) begin
            set_extract_mode(ph == 0 ? MODE_MAX : ph == 1 ? MODE_MIN
                                                         : logic'($urandom_range(0, 1)));
            idle_on = (ph != 2 && ph != 7);
            for (int n = 0; n < 203; n++) begin
                cmd = ($urandom_range(0, 99) < ins_pct[ph]) ? CMD_INSERT : CMD_REMOVE;
                push_command(cmd, pick_value());
            end
        end

        s_valid <= 1'b0;
        @(posedge clk);
        while (sb.outcomes.size() != 0) @(posedge clk);
        repeat (CAPACITY + 10) @(posedge clk);
        if (sb.errors == 0 && sb.outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/lees_pkg.sv
rtl/lees_cell.sv
rtl/linear_extreme_extract_store.sv
dv/linear_extreme_extract_store_tb.sv
